@@ rtl/core/olbu_pkg.sv @@
// Shared types, constants and register codes for the log-odds batch update block.
`default_nettype none
package olbu_pkg;
  localparam int CellsDef     = 4096;
  localparam int CountBitsDef = 8;
  localparam int IdxW         = 12;
  localparam int ValW         = 16;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_DRAIN  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_HIT_STEP   = 3'd0,
    REG_MISS_STEP  = 3'd1,
    REG_UPPER      = 3'd2,
    REG_LOWER      = 3'd3,
    REG_UNKNOWN    = 3'd4
  } reg_idx_t;

  // One classified item passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]      mode;
    logic [IdxW-1:0] idx;
    logic            is_hit;
    logic            in_range;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/occupancy_logodds_batch_update_top.sv @@
// Top level of the log-odds occupancy batch update block.
// The back part runs one command at a time. A record or a read goes through fetch,
// update and result beat (out of range: straight to the result beat), a drain
// through queue fetch, cell fetch, multiply, write back and result beat, a drain on
// an empty queue straight to its result beat, and a clear rewrites every entry, one
// per cycle, before its result beat goes out. After reset the same sweep runs before
// the first command is taken. While the back part is busy, the two-entry command
// queue takes at most two more items and then stalls the input; configuration writes
// are taken at any time. The result register holds a finished beat until taken.
`default_nettype none
module occupancy_logodds_batch_update_top #(
  parameter int Cells     = olbu_pkg::CellsDef,
  parameter int CountBits = olbu_pkg::CountBitsDef
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [olbu_pkg::IdxW-1:0]   in_cell_index,
  input  wire logic                        in_is_hit,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [olbu_pkg::IdxW-1:0]        out_out_cell,
  output logic signed [15:0]               out_cell_value,
  output logic                             out_entry_valid,
  output logic                             out_queue_empty,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [15:0]                 cfg_data
);
  import olbu_pkg::*;
  logic [14:0] hit_step_r;
  logic signed [15:0] miss_r, upper_r, lower_r, unk_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_step_r <= 15'd217; miss_r <= -16'sd51; upper_r <= 16'sd512;
      lower_r <= -16'sd512; unk_r <= 16'sd221;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HIT_STEP:  hit_step_r <= cfg_data[14:0];
        REG_MISS_STEP: miss_r <= cfg_data;
        REG_UPPER:     upper_r <= cfg_data;
        REG_LOWER:     lower_r <= cfg_data;
        REG_UNKNOWN:   unk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  olbu_front #(.Cells(Cells)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_cell_index(in_cell_index), .in_is_hit(in_is_hit),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd));

  olbu_back #(.Cells(Cells), .CountBits(CountBits)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .hit_step(hit_step_r), .miss_step(miss_r), .upper_clamp(upper_r),
    .lower_clamp(lower_r), .unknown_value(unk_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_out_cell(out_out_cell),
    .out_cell_value(out_cell_value), .out_entry_valid(out_entry_valid),
    .out_queue_empty(out_queue_empty));
endmodule
`default_nettype wire

@@ rtl/core/olbu_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module olbu_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/olbu_front.sv @@
// Front part: takes input beats, checks the index range and queues them as commands.
`default_nettype none
module olbu_front #(
  parameter int Cells = olbu_pkg::CellsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_mode,
  input  wire logic [olbu_pkg::IdxW-1:0] in_cell_index,
  input  wire logic                   in_is_hit,
  output logic                        cmd_valid,
  input  wire logic                   cmd_take,
  output olbu_pkg::cmd_t              cmd
);
  import olbu_pkg::*;
  // Two-entry queue.
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt;
  logic push, pop;
  cmd_t inc;

  always_comb begin
    inc.mode     = in_mode;
    inc.idx      = in_cell_index;
    inc.is_hit   = in_is_hit;
    inc.in_range = ({1'b0, in_cell_index} < (IdxW+1)'(Cells > 4096 ? 4096 : Cells));
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rd_r];
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};
  assign rd_nxt    = pop ? ~rd_r : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
    if (push) q_r[rd_r ^ cnt_r[0] ^ (cnt_r[1] & 1'b0)] <= inc;
  end
endmodule
`default_nettype wire

@@ rtl/core/olbu_back.sv @@
// Back part: sequencer over the store, counter and pending-queue memories.
`default_nettype none
module olbu_back #(
  parameter int Cells     = olbu_pkg::CellsDef,
  parameter int CountBits = olbu_pkg::CountBitsDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cmd_valid,
  output logic                           cmd_take,
  input  olbu_pkg::cmd_t                 cmd,
  input  wire logic [14:0]               hit_step,
  input  wire logic signed [15:0]        miss_step,
  input  wire logic signed [15:0]        upper_clamp,
  input  wire logic signed [15:0]        lower_clamp,
  input  wire logic signed [15:0]        unknown_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [olbu_pkg::IdxW-1:0]      out_out_cell,
  output logic signed [15:0]             out_cell_value,
  output logic                           out_entry_valid,
  output logic                           out_queue_empty
);
  import olbu_pkg::*;
  localparam int AW = $clog2(Cells);
  localparam int FW = AW + 1;
  localparam logic [CountBits-1:0] CMax = '1;

  typedef enum logic [2:0] {S_WIPE, S_IDLE, S_RD, S_MUL, S_WR, S_OUT} state_t;
  state_t state_r;

  logic [AW-1:0] addr_r, wipe_r, head_r;
  logic [FW-1:0] fill_r;
  cmd_t c_r;
  logic [1:0] m_r;

  // Memory ports.
  logic          v_we, k_we, q_we;
  logic [AW-1:0] v_a, k_a, q_a;
  logic [15:0]   v_wd, v_rd;
  logic [2*CountBits-1:0] k_wd, k_rd;
  logic [AW-1:0] q_wd, q_rd;

  olbu_ram #(.Width(16), .Depth(Cells)) u_val (
    .clk(clk), .we(v_we), .addr(v_a), .wdata(v_wd), .rdata(v_rd));
  olbu_ram #(.Width(2*CountBits), .Depth(Cells)) u_cnt (
    .clk(clk), .we(k_we), .addr(k_a), .wdata(k_wd), .rdata(k_rd));
  olbu_ram #(.Width(AW), .Depth(Cells)) u_q (
    .clk(clk), .we(q_we), .addr(q_a), .wdata(q_wd), .rdata(q_rd));

  logic [CountBits-1:0] obs, hits, obs_n, hits_n;
  assign obs  = k_rd[2*CountBits-1:CountBits];
  assign hits = k_rd[CountBits-1:0];
  assign obs_n  = (obs == CMax) ? obs : obs + 1'b1;
  assign hits_n = (c_r.is_hit && hits != CMax) ? hits + 1'b1 : hits;

  logic signed [40:0] prod_r, sum;
  logic signed [15:0] newv;
  logic had_hits_r;
  logic [AW-1:0] tail;
  assign tail = head_r + fill_r[AW-1:0];
  assign sum  = prod_r + 41'($signed(v_rd));

  always_comb begin
    if (had_hits_r) begin
      if (sum > 41'(upper_clamp)) newv = upper_clamp;
      else if (sum < -41'sd32768) newv = -16'sd32768;
      else newv = sum[15:0];
    end else begin
      if (sum < 41'(lower_clamp)) newv = lower_clamp;
      else if (sum > 41'sd32767) newv = 16'sd32767;
      else newv = sum[15:0];
    end
  end

  always_comb begin
    v_we = 1'b0; k_we = 1'b0; q_we = 1'b0;
    v_a = addr_r; k_a = addr_r; q_a = head_r;
    v_wd = newv; k_wd = '0; q_wd = addr_r;
    case (state_r)
      S_WIPE: begin
        v_we = 1'b1; k_we = 1'b1; v_a = wipe_r; k_a = wipe_r; v_wd = unknown_value;
      end
      S_IDLE: begin
        v_a = cmd.idx[AW-1:0]; k_a = cmd.idx[AW-1:0];
      end
      S_MUL: begin
        if (m_r == MODE_RECORD) begin
          k_we = 1'b1; k_wd = {obs_n, hits_n};
          if (obs == '0) begin
            q_we = 1'b1; q_a = tail;
          end
        end
      end
      S_WR: begin
        if (m_r == MODE_DRAIN) begin
          v_we = 1'b1; k_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      wipe_r <= '0; head_r <= '0; fill_r <= '0;
      m_r <= MODE_RECORD;
    end else begin
      case (state_r)
        S_WIPE: begin
          wipe_r <= wipe_r + 1'b1;
          // A clear sends its result beat once the sweep is done.
          if (wipe_r == AW'(Cells-1)) state_r <= (m_r == MODE_CLEAR) ? S_OUT : S_IDLE;
        end
        S_IDLE: if (cmd_valid) begin
          c_r <= cmd; m_r <= cmd.mode;
          addr_r <= cmd.idx[AW-1:0];
          out_out_cell <= cmd.idx;
          out_cell_value <= '0;
          out_entry_valid <= 1'b0;
          case (cmd.mode)
            MODE_CLEAR: begin
              out_out_cell <= '0;
              out_cell_value <= unknown_value;
              out_entry_valid <= 1'b1;
              head_r <= '0; fill_r <= '0; wipe_r <= '0;
              out_queue_empty <= 1'b1;
              state_r <= S_WIPE;
            end
            MODE_DRAIN: begin
              out_out_cell <= '0;
              out_queue_empty <= (fill_r <= FW'(1));
              if (fill_r == '0) state_r <= S_OUT;
              else state_r <= S_RD;
            end
            default: begin
              out_queue_empty <= (fill_r == '0);
              if (cmd.in_range) state_r <= S_RD;
              else state_r <= S_OUT;
            end
          endcase
        end
        S_RD: begin
          if (m_r == MODE_DRAIN) begin
            // Queue entry now valid; fetch the cell itself.
            addr_r <= q_rd;
            head_r <= head_r + 1'b1;
            fill_r <= fill_r - 1'b1;
            out_out_cell <= IdxW'(q_rd);
            m_r <= MODE_CLEAR;
          end else state_r <= S_MUL;
        end
        S_MUL: begin
          if (m_r == MODE_CLEAR) begin
            m_r <= MODE_DRAIN;
          end else if (m_r == MODE_DRAIN) begin
            had_hits_r <= (hits != '0);
            if (hits != '0)
              prod_r <= 41'($signed({1'b0, hit_step}) * $signed({1'b0, hits}));
            else
              prod_r <= 41'(miss_step * $signed({1'b0, obs}));
            state_r <= S_WR;
          end else begin
            if (m_r == MODE_RECORD && obs == '0) begin
              fill_r <= fill_r + 1'b1;
              out_queue_empty <= 1'b0;
            end
            out_cell_value <= v_rd;
            out_entry_valid <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_WR: begin
          out_cell_value <= newv;
          out_entry_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the log-odds occupancy batch update block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import olbu_pkg::*;

  localparam int NCELL = 4096;
  localparam int CMAX = 255;
  localparam int SWEEP_WAIT = 4300;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [11:0]        idx;
    logic signed [15:0] value;
    logic               ev;
    logic               qe;
  } beat_t;

  typedef struct {
    mode_t       mode;
    logic [11:0] idx;
    logic        hit;
    bit          typed;
    beat_t       want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_mode = 0;
  logic [11:0] in_cell_index = 0;
  logic in_is_hit = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [11:0] out_out_cell;
  logic signed [15:0] out_cell_value;
  logic out_entry_valid;
  logic out_queue_empty;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  occupancy_logodds_batch_update_top u_top (.*);

  always #2 clk = ~clk;

  // Mirror of the map, counters, pending FIFO and registers.
  logic signed [15:0] map_val [NCELL];
  int obs_cnt [NCELL];
  int hit_cnt [NCELL];
  int pend [NCELL];
  int q_head, q_fill;
  int hit_step, miss_step, upper_lim, lower_lim, unk_val;

  beat_t expected_beats[$];
  int errors = 0;
  bit tx_busy = 1, rx_busy = 1, hold_req = 0;
  int hold_left = 0, rx_wait = 0, idle_cycles = 0, items = 0;

  function automatic void wipe_map();
    for (int i = 0; i < NCELL; i++) begin
      map_val[i] = unk_val[15:0];
      obs_cnt[i] = 0;
      hit_cnt[i] = 0;
    end
    q_head = 0;
    q_fill = 0;
  endfunction

  function automatic beat_t update_cell(mode_t m, int c, logic h);
    beat_t r;
    longint v;
    int p;
    r = '0;
    case (m)
      MODE_RECORD: begin
        if (obs_cnt[c] < CMAX) begin
          obs_cnt[c]++;
          if (obs_cnt[c] == 1) begin
            pend[(q_head + q_fill) % NCELL] = c;
            q_fill++;
          end
        end
        if (h && hit_cnt[c] < CMAX) hit_cnt[c]++;
        r.idx = 12'(c);
        r.value = map_val[c];
        r.ev = 1;
      end
      MODE_DRAIN: begin
        if (q_fill > 0) begin
          p = pend[q_head];
          q_head = (q_head + 1) % NCELL;
          q_fill--;
          v = map_val[p];
          if (hit_cnt[p] > 0) begin
            v += longint'(hit_step) * hit_cnt[p];
            if (v > upper_lim) v = upper_lim;
          end else begin
            v += longint'(miss_step) * obs_cnt[p];
            if (v < lower_lim) v = lower_lim;
          end
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          map_val[p] = v[15:0];
          hit_cnt[p] = 0;
          obs_cnt[p] = 0;
          r.idx = 12'(p);
          r.value = map_val[p];
          r.ev = 1;
        end
      end
      MODE_READ: begin
        r.idx = 12'(c);
        r.value = map_val[c];
        r.ev = 1;
      end
      default: begin
        wipe_map();
        r.value = unk_val[15:0];
        r.ev = 1;
      end
    endcase
    r.qe = (q_fill == 0);
    return r;
  endfunction

  task automatic send_beat(mode_t m, logic [11:0] c, logic h, bit typed, beat_t want);
    int gap;
    beat_t p;
    gap = tx_busy ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= m;
    in_cell_index <= c;
    in_is_hit <= h;
    do @(posedge clk); while (in_stall);
    p = update_cell(m, int'(c), h);
    if (typed) p = want;
    expected_beats = {expected_beats, p};
    items++;
  endtask

  task automatic drain_out();
    in_valid <= 0;
    wait (expected_beats.size() == 0);
    @(posedge clk);
  endtask

  // Registers are only written with the block quiet and any clear sweep over.
  task automatic write_reg(reg_idx_t idx, logic [15:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_HIT_STEP:  hit_step = int'(d[14:0]);
      REG_MISS_STEP: miss_step = int'($signed(d));
      REG_UPPER:     upper_lim = int'($signed(d));
      REG_LOWER:     lower_lim = int'($signed(d));
      default:       unk_val = int'($signed(d));
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int hs, int ms, int up, int lo, int uk);
    drain_out();
    repeat (SWEEP_WAIT) @(posedge clk);
    write_reg(REG_HIT_STEP, hs[15:0]);
    write_reg(REG_MISS_STEP, ms[15:0]);
    write_reg(REG_UPPER, up[15:0]);
    write_reg(REG_LOWER, lo[15:0]);
    write_reg(REG_UNKNOWN, uk[15:0]);
  endtask

  task automatic random_phase(int n);
    int pool [8];
    int c, sel;
    beat_t none;
    none = '0;
    foreach (pool[i]) pool[i] = $urandom_range(0, NCELL - 1);
    for (int k = 0; k < n; k++) begin
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NCELL - 1)
                                      : pool[$urandom_range(0, 7)];
      sel = $urandom_range(0, 99);
      if (k == n / 2) drain_out();
      if (sel < 60) send_beat(MODE_RECORD, 12'(c), 1'($urandom_range(0, 1)), 0, none);
      else if (sel < 87) send_beat(MODE_DRAIN, 12'(c), 1'($urandom_range(0, 1)), 0, none);
      else if (sel < 98) send_beat(MODE_READ, 12'(c), 1'($urandom_range(0, 1)), 0, none);
      else send_beat(MODE_CLEAR, 12'(c), 1'($urandom_range(0, 1)), 0, none);
    end
  endtask

  function automatic row_t mk(mode_t m, int c, logic h, bit t = 0, int ec = 0, int ev = 0,
                              logic v = 0, logic q = 0);
    row_t r;
    r.mode = m;
    r.idx = 12'(c);
    r.hit = h;
    r.typed = t;
    r.want.idx = 12'(ec);
    r.want.value = 16'(ev);
    r.want.ev = v;
    r.want.qe = q;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    beat_t none;
    none = '0;
    hit_step = 217;
    miss_step = -51;
    upper_lim = 512;
    lower_lim = -512;
    unk_val = 221;
    foreach (pend[i]) pend[i] = 0;
    wipe_map();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    rows = {rows, mk(MODE_READ, 0, 0, 1, 0, 221, 1, 1)};
    rows = {rows, mk(MODE_READ, 4095, 1, 1, 4095, 221, 1, 1)};
    rows = {rows, mk(MODE_DRAIN, 0, 0, 1, 0, 0, 0, 1)};
    rows = {rows, mk(MODE_RECORD, 4095, 1, 1, 4095, 221, 1, 0)};
    rows = {rows, mk(MODE_RECORD, 4095, 0)};
    rows = {rows, mk(MODE_RECORD, 0, 0)};
    rows = {rows, mk(MODE_RECORD, 0, 0)};
    rows = {rows, mk(MODE_RECORD, 12'hAAA, 1)};
    rows = {rows, mk(MODE_RECORD, 12'h555, 0)};
    rows = {rows, mk(MODE_DRAIN, 0, 0)};
    rows = {rows, mk(MODE_DRAIN, 4095, 1)};
    rows = {rows, mk(MODE_READ, 0, 0)};
    rows = {rows, mk(MODE_DRAIN, 0, 0)};
    rows = {rows, mk(MODE_DRAIN, 0, 0)};
    rows = {rows, mk(MODE_DRAIN, 0, 0, 1, 0, 0, 0, 1)};
    rows = {rows, mk(MODE_READ, 4095, 0)};
    rows = {rows, mk(MODE_RECORD, 7, 1)};
    rows = {rows, mk(MODE_CLEAR, 12'hFFF, 1, 1, 0, 221, 1, 1)};
    rows = {rows, mk(MODE_READ, 12'hAAA, 0, 1, 12'hAAA, 221, 1, 1)};
    foreach (rows[i]) send_beat(rows[i].mode, rows[i].idx, rows[i].hit, rows[i].typed,
                                rows[i].want);

    // Counter saturation: two cells observed past the counter maximum, one with hits, one without.
    for (int k = 0; k < 262; k++) send_beat(MODE_RECORD, 12'd100, k < 130, 0, none);
    for (int k = 0; k < 262; k++) send_beat(MODE_RECORD, 12'd200, 1'b0, 0, none);
    send_beat(MODE_DRAIN, 12'd0, 1'b0, 0, none);
    send_beat(MODE_DRAIN, 12'd0, 1'b0, 0, none);
    random_phase(60);

    // Long receiver hold while the sender keeps pushing.
    drain_out();
    tx_busy = 0;
    hold_req = 1;
    for (int k = 0; k < 30; k++) send_beat(MODE_RECORD, 12'($urandom_range(0, 4095)),
                                           1'($urandom_range(0, 1)), 0, none);
    tx_busy = 1;

    set_regs(32767, -32768, 32767, -32768, 32767);
    send_beat(MODE_CLEAR, 12'd0, 1'b0, 0, none);
    random_phase(120);
    set_regs(0, 0, -32768, 32767, -32768);
    send_beat(MODE_CLEAR, 12'd0, 1'b0, 0, none);
    rx_busy = 0;
    random_phase(100);
    rx_busy = 1;
    set_regs(32767, -32768, -32768, 32767, 0);
    send_beat(MODE_CLEAR, 12'd0, 1'b0, 0, none);
    tx_busy = 0;
    random_phase(100);
    tx_busy = 1;
    while (items < 1150) begin
      set_regs($urandom_range(0, 2000), -$urandom_range(0, 2000),
               $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
               $urandom_range(0, 65535));
      send_beat(MODE_CLEAR, 12'd0, 1'b0, 0, none);
      random_phase(120);
    end
    set_regs(217, -51, 512, -512, 221);
    send_beat(MODE_CLEAR, 12'd0, 1'b0, 0, none);
    random_phase(20);

    drain_out();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    beat_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rx_wait = rx_busy ? $urandom_range(0, 11) : 0;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected, cell %0d", out_out_cell);
          errors++;
        end else begin
          w = expected_beats.pop_front();
          if (out_out_cell !== w.idx) begin
            $error("out_cell: expected %0d, got %0d", w.idx, out_out_cell);
            errors++;
          end
          if (out_cell_value !== w.value) begin
            $error("cell_value: expected %0d, got %0d", w.value, out_cell_value);
            errors++;
          end
          if (out_entry_valid !== w.ev) begin
            $error("entry_valid: expected %0d, got %0d", w.ev, out_entry_valid);
            errors++;
          end
          if (out_queue_empty !== w.qe) begin
            $error("queue_empty: expected %0d, got %0d", w.qe, out_queue_empty);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = 300;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule
`default_nettype wire
